>>> rtl/srvb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srvb_pkg
// Shared types, constants and arithmetic helpers for the Schroeder reverb.
// ----------------------------------------------------------------------------
package srvb_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int STORE_W     = 24;
  localparam int GAIN_W      = 16;
  localparam int DLY_W       = 13;
  localparam int DRY_W       = 17;
  localparam int PROD_W      = 41;
  localparam int RND_W       = 26;
  localparam int TERM_W      = 27;
  localparam int DIV_MULT_W  = 26;
  localparam int AP_GAIN_LSB = 26;

  localparam int COMB_COUNT_DEF    = 4;
  localparam int ALLPASS_COUNT_DEF = 2;
  localparam int DELAY_DEPTH_DEF   = 8192;

  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int COMB_DLY_REG_W  = 52;
  localparam int COMB_GAIN_REG_W = 64;
  localparam int AP_REG_W        = 58;

  localparam logic [CFG_IDX_W-1:0] CFG_COMB_DELAYS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMB_GAINS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AP_SETTINGS = 2'd2;

  localparam logic [COMB_DLY_REG_W-1:0]  COMB_DELAYS_RST = 52'd549822930945;
  localparam logic [COMB_GAIN_REG_W-1:0] COMB_GAINS_RST  = 64'd92325201131864392;
  localparam logic [AP_REG_W-1:0]        AP_SETTINGS_RST = 58'd1442581267357697;

  // Datapath operations, one per controller cycle
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_C_RD,
    OP_C_MUL,
    OP_C_SUM,
    OP_C_WR,
    OP_MIX,
    OP_A_RD,
    OP_A_MULX,
    OP_A_MULO,
    OP_A_SUM,
    OP_A_WR,
    OP_MOD,
    OP_DIV_MUL,
    OP_DIV_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_C_RD,
    ST_C_MUL,
    ST_C_SUM,
    ST_C_WR,
    ST_C_MOD,
    ST_MIX,
    ST_A_RD,
    ST_A_MULX,
    ST_A_MULO,
    ST_A_SUM,
    ST_A_WR,
    ST_A_MOD,
    ST_D_MUL,
    ST_D_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;  // final word of the clearing sweep
    logic need_mod;    // head wrap needs the iterative remainder
    logic mod_last;    // final remainder step
    logic out_free;    // output register can take a beat
  } dp_sts_t;

  function automatic int min1_clog2(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int idx_w(input int c, input int a);
    return min1_clog2((c > a) ? c : a);
  endfunction

  function automatic logic signed [STORE_W-1:0] sat_s24(input logic signed [31:0] v);
    if (v > 32'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      return 24'sh800000;
    end
    return v[STORE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_s16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Q1.15 gain product back to sample scale, round half up
  function automatic logic signed [RND_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + 41'sd16384;
    return t[PROD_W-1:15];
  endfunction

endpackage

>>> rtl/srvb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srvb_ctrl
// Sequencer: walks the combs, then the allpass chain, then the final scale.
// ----------------------------------------------------------------------------
module srvb_ctrl import srvb_pkg::*; #(
  parameter int COMB_COUNT    = COMB_COUNT_DEF,
  parameter int ALLPASS_COUNT = ALLPASS_COUNT_DEF,
  localparam int IW           = idx_w(COMB_COUNT, ALLPASS_COUNT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dp_sts_t       sts,
  output dp_cmd_t       cmd,
  output logic [IW-1:0] idx
);

  ctrl_state_t   state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_C_RD;
          idx_nxt   = '0;
        end
      end
      ST_C_RD:  state_nxt = ST_C_MUL;
      ST_C_MUL: state_nxt = ST_C_SUM;
      ST_C_SUM: state_nxt = ST_C_WR;
      ST_C_WR, ST_C_MOD: begin
        if (state_r == ST_C_WR && sts.need_mod) begin
          state_nxt = ST_C_MOD;
        end else if (state_r == ST_C_WR || sts.mod_last) begin
          if (idx_r == IW'(COMB_COUNT - 1)) begin
            state_nxt = ST_MIX;
            idx_nxt   = '0;
          end else begin
            state_nxt = ST_C_RD;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      ST_MIX:    state_nxt = ST_A_RD;
      ST_A_RD:   state_nxt = ST_A_MULX;
      ST_A_MULX: state_nxt = ST_A_MULO;
      ST_A_MULO: state_nxt = ST_A_SUM;
      ST_A_SUM:  state_nxt = ST_A_WR;
      ST_A_WR, ST_A_MOD: begin
        if (state_r == ST_A_WR && sts.need_mod) begin
          state_nxt = ST_A_MOD;
        end else if (state_r == ST_A_WR || sts.mod_last) begin
          if (idx_r == IW'(ALLPASS_COUNT - 1)) begin
            state_nxt = ST_D_MUL;
            idx_nxt   = '0;
          end else begin
            state_nxt = ST_A_RD;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      ST_D_MUL: state_nxt = ST_D_OUT;
      ST_D_OUT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NOP;
    unique case (state_r)
      ST_CLEAR:  cmd.op = OP_CLEAR;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? OP_LOAD : OP_NOP;
      end
      ST_C_RD:   cmd.op = OP_C_RD;
      ST_C_MUL:  cmd.op = OP_C_MUL;
      ST_C_SUM:  cmd.op = OP_C_SUM;
      ST_C_WR:   cmd.op = OP_C_WR;
      ST_C_MOD:  cmd.op = OP_MOD;
      ST_MIX:    cmd.op = OP_MIX;
      ST_A_RD:   cmd.op = OP_A_RD;
      ST_A_MULX: cmd.op = OP_A_MULX;
      ST_A_MULO: cmd.op = OP_A_MULO;
      ST_A_SUM:  cmd.op = OP_A_SUM;
      ST_A_WR:   cmd.op = OP_A_WR;
      ST_A_MOD:  cmd.op = OP_MOD;
      ST_D_MUL:  cmd.op = OP_DIV_MUL;
      ST_D_OUT:  cmd.op = sts.out_free ? OP_DIV_OUT : OP_NOP;
      default:   cmd.op = OP_NOP;
    endcase
  end

  assign idx = idx_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && state_r == ST_C_RD && idx_r == '0))
    else $error("item accepted without starting the comb walk at filter zero");

  a_mod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_MOD && !sts.mod_last) |=> (cmd.op == OP_MOD && $stable(idx_r)))
    else $error("remainder left before its last step");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && sts.clear_last) |=> (state_r == ST_IDLE))
    else $error("clearing sweep did not hand over to idle");

endmodule

>>> rtl/srvb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srvb_dp
// Datapath: settings, delay memories, heads, shared multiplier, remainder
// unit, final scale and output register.
// ----------------------------------------------------------------------------
module srvb_dp import srvb_pkg::*; #(
  parameter int COMB_COUNT    = COMB_COUNT_DEF,
  parameter int ALLPASS_COUNT = ALLPASS_COUNT_DEF,
  parameter int DELAY_DEPTH   = DELAY_DEPTH_DEF,
  localparam int IW           = idx_w(COMB_COUNT, ALLPASS_COUNT)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  input  logic [IW-1:0]              idx,
  output dp_sts_t                    sts,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_wet_sample,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int HW         = $clog2(DELAY_DEPTH);
  localparam int NW         = HW + 1;
  localparam int EW         = (NW > DLY_W) ? NW : DLY_W;
  localparam int CW         = min1_clog2(COMB_COUNT);
  localparam int PW         = min1_clog2(ALLPASS_COUNT);
  localparam int CAW        = CW + HW;
  localparam int PAW        = PW + HW;
  localparam int COMB_WORDS = COMB_COUNT << HW;
  localparam int AP_WORDS   = ALLPASS_COUNT << HW;
  localparam int CLR_WORDS  = (COMB_WORDS > AP_WORDS) ? COMB_WORDS : AP_WORDS;
  localparam int CLW        = min1_clog2(CLR_WORDS);
  localparam int CLW1       = CLW + 1;
  localparam int MCW        = min1_clog2(NW);
  localparam int ACC_W      = STORE_W + $clog2(COMB_COUNT + 1);
  localparam int NF         = COMB_COUNT + ALLPASS_COUNT;
  localparam int DIV_SHIFT  = STORE_W + $clog2(NF);
  localparam logic [DIV_MULT_W-1:0] DIV_MULT =
    DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(NF) - 64'd1) / 64'(NF));
  localparam int DPROD_W    = STORE_W + DIV_MULT_W;

  // Zero acts as one, long delays clamp to the memory depth
  function automatic logic [NW-1:0] eff_delay(input logic [DLY_W-1:0] f);
    logic [EW-1:0] v;
    v = (f == '0) ? EW'(1) : EW'(f);
    if (v > EW'(DELAY_DEPTH)) v = EW'(DELAY_DEPTH);
    return NW'(v);
  endfunction

  logic [COMB_DLY_REG_W-1:0]  comb_delays_r;
  logic [COMB_GAIN_REG_W-1:0] comb_gains_r;
  logic [AP_REG_W-1:0]        ap_set_r;

  logic [HW-1:0] comb_head_r [COMB_COUNT];
  logic [HW-1:0] ap_head_r   [ALLPASS_COUNT];

  logic [STORE_W-1:0]   comb_mem [COMB_WORDS];
  logic [2*STORE_W-1:0] ap_mem   [AP_WORDS];
  logic [STORE_W-1:0]   comb_rd_r;
  logic [2*STORE_W-1:0] ap_rd_r;

  logic signed [DRY_W-1:0]   dry_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [STORE_W-1:0] x_r;
  logic signed [STORE_W-1:0] y_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [TERM_W-1:0]  term_r;
  logic [DPROD_W-1:0]        dprod_r;
  logic [CLW-1:0]            clr_cnt_r;
  logic [HW:0]               mod_rem_r;
  logic [HW:0]               mod_q_r;
  logic [HW:0]               mod_d_r;
  logic [MCW-1:0]            mod_cnt_r;
  logic                      mod_ap_r;
  logic                      out_valid_r;
  logic signed [SAMPLE_W-1:0] wet_r;

  logic [1:0]                cf;
  logic                      af;
  logic [CW-1:0]             ci;
  logic [PW-1:0]             pi;
  logic [NW-1:0]             comb_d, ap_d, cur_d;
  logic [GAIN_W-1:0]         comb_g, ap_g, mul_g;
  logic [HW-1:0]             cur_h, fast_h;
  logic [NW-1:0]             next_n;
  logic                      is_ap_wr, need_mod, mod_done;
  logic [HW+1:0]             mod_t, mod_sub;
  logic signed [STORE_W-1:0] mul_v;
  logic signed [PROD_W-1:0]  prod;
  logic signed [RND_W-1:0]   rnd;
  logic signed [STORE_W-1:0] ap_in, ap_out;
  logic [STORE_W-1:0]        mag, dq;
  logic [31:0]               dval;
  logic                      comb_we, ap_we, clr_in_comb, clr_in_ap;
  logic [CAW-1:0]            comb_addr;
  logic [PAW-1:0]            ap_addr;

  // Settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comb_delays_r <= COMB_DELAYS_RST;
      comb_gains_r  <= COMB_GAINS_RST;
      ap_set_r      <= AP_SETTINGS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMB_DELAYS: comb_delays_r <= cfg_wdata[COMB_DLY_REG_W-1:0];
        CFG_COMB_GAINS:  comb_gains_r  <= cfg_wdata[COMB_GAIN_REG_W-1:0];
        CFG_AP_SETTINGS: ap_set_r      <= cfg_wdata[AP_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Filter k takes field k mod 4 (combs) or k mod 2 (allpasses)
  assign cf     = 2'(idx);
  assign af     = idx[0];
  assign ci     = CW'(idx);
  assign pi     = PW'(idx);
  assign comb_d = eff_delay(comb_delays_r[DLY_W*cf +: DLY_W]);
  assign comb_g = comb_gains_r[GAIN_W*cf +: GAIN_W];
  assign ap_d   = eff_delay(ap_set_r[DLY_W*af +: DLY_W]);
  assign ap_g   = ap_set_r[AP_GAIN_LSB + GAIN_W*af +: GAIN_W];

  // Head advance: fast path unless a shortened delay left the head past it
  assign is_ap_wr = (cmd.op == OP_A_WR);
  assign cur_h    = is_ap_wr ? ap_head_r[pi] : comb_head_r[ci];
  assign cur_d    = is_ap_wr ? ap_d : comb_d;
  assign next_n   = {1'b0, cur_h} + NW'(1);
  assign need_mod = (next_n > cur_d);
  assign fast_h   = (next_n == cur_d) ? '0 : next_n[HW-1:0];

  // One restoring remainder step a cycle
  assign mod_t    = {mod_rem_r, mod_q_r[HW]};
  assign mod_sub  = (mod_t >= {1'b0, mod_d_r}) ? (mod_t - {1'b0, mod_d_r}) : mod_t;
  assign mod_done = (cmd.op == OP_MOD) && (mod_cnt_r == '0);

  always_ff @(posedge clk) begin
    if ((cmd.op == OP_C_WR || cmd.op == OP_A_WR) && need_mod) begin
      mod_rem_r <= '0;
      mod_q_r   <= next_n;
      mod_d_r   <= cur_d;
      mod_cnt_r <= MCW'(HW);
      mod_ap_r  <= is_ap_wr;
    end else if (cmd.op == OP_MOD) begin
      mod_rem_r <= mod_sub[HW:0];
      mod_q_r   <= {mod_q_r[HW-1:0], 1'b0};
      mod_cnt_r <= mod_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COMB_COUNT; i++) comb_head_r[i] <= '0;
      for (int i = 0; i < ALLPASS_COUNT; i++) ap_head_r[i] <= '0;
    end else begin
      if (cmd.op == OP_C_WR && !need_mod) comb_head_r[ci] <= fast_h;
      if (cmd.op == OP_A_WR && !need_mod) ap_head_r[pi] <= fast_h;
      if (mod_done) begin
        if (mod_ap_r) ap_head_r[pi] <= mod_sub[HW-1:0];
        else          comb_head_r[ci] <= mod_sub[HW-1:0];
      end
    end
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign clr_in_comb = ({1'b0, clr_cnt_r} < CLW1'(COMB_WORDS));
  assign clr_in_ap   = ({1'b0, clr_cnt_r} < CLW1'(AP_WORDS));

  // Delay memories: one write and one registered read port each
  assign comb_we   = (cmd.op == OP_CLEAR && clr_in_comb) || (cmd.op == OP_C_WR);
  assign ap_we     = (cmd.op == OP_CLEAR && clr_in_ap) || (cmd.op == OP_A_WR);
  assign comb_addr = (cmd.op == OP_CLEAR) ? CAW'(clr_cnt_r) : {ci, comb_head_r[ci]};
  assign ap_addr   = (cmd.op == OP_CLEAR) ? PAW'(clr_cnt_r) : {pi, ap_head_r[pi]};

  always_ff @(posedge clk) begin
    if (comb_we) comb_mem[comb_addr] <= (cmd.op == OP_CLEAR) ? '0 : y_r;
    if (cmd.op == OP_C_RD) comb_rd_r <= comb_mem[comb_addr];
  end

  always_ff @(posedge clk) begin
    if (ap_we) ap_mem[ap_addr] <= (cmd.op == OP_CLEAR) ? '0 : {x_r, y_r};
    if (cmd.op == OP_A_RD) ap_rd_r <= ap_mem[ap_addr];
  end

  // Shared gain multiplier
  assign ap_in  = ap_rd_r[2*STORE_W-1:STORE_W];
  assign ap_out = ap_rd_r[STORE_W-1:0];
  assign mul_g  = (cmd.op == OP_C_MUL) ? comb_g : ap_g;
  always_comb begin
    unique case (cmd.op)
      OP_C_MUL:  mul_v = comb_rd_r;
      OP_A_MULX: mul_v = x_r;
      default:   mul_v = ap_out;
    endcase
  end
  assign prod = $signed({1'b0, mul_g}) * mul_v;
  assign rnd  = round_q15(prod_r);

  // Final scale by 1/(combs + allpasses): reciprocal multiply on the magnitude
  assign mag  = x_r[STORE_W-1] ? STORE_W'(-x_r) : STORE_W'(x_r);
  assign dq   = STORE_W'(dprod_r >> DIV_SHIFT);
  assign dval = x_r[STORE_W-1] ? (-32'(dq)) : 32'(dq);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        dry_r <= DRY_W'(in_left_sample) + DRY_W'(in_right_sample);
        acc_r <= '0;
      end
      OP_C_MUL, OP_A_MULX: prod_r <= prod;
      OP_A_MULO: begin
        prod_r <= prod;
        term_r <= TERM_W'(ap_in) - TERM_W'(rnd);
      end
      OP_C_SUM:   y_r <= sat_s24(32'(dry_r) + 32'(rnd));
      OP_A_SUM:   y_r <= sat_s24(32'(term_r) + 32'(rnd));
      OP_C_WR:    acc_r <= acc_r + ACC_W'(y_r);
      OP_MIX:     x_r <= sat_s24(32'(acc_r));
      OP_A_WR:    x_r <= y_r;
      OP_DIV_MUL: dprod_r <= DPROD_W'(mag) * DPROD_W'(DIV_MULT);
      OP_DIV_OUT: wet_r <= sat_s16(dval);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_DIV_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_wet_sample = wet_r;

  assign sts.clear_last = (clr_cnt_r == CLW'(CLR_WORDS - 1));
  assign sts.need_mod   = need_mod;
  assign sts.mod_last   = (mod_cnt_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV_OUT) |-> (!out_valid_r || out_ready))
    else $error("result loaded over a beat not yet taken");

  a_mod_start: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.op == OP_C_WR || cmd.op == OP_A_WR) && need_mod)
      |=> (mod_cnt_r == MCW'(HW) && mod_d_r != '0))
    else $error("remainder unit not armed after a long head");

endmodule

>>> rtl/schroeder_reverb_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schroeder_reverb_core
// Mono Schroeder reverberator: parallel feedback combs into series allpasses.
// ----------------------------------------------------------------------------
// Each input beat carries a left and a right Q1.15 sample; they are summed,
// run through COMB_COUNT feedback combs whose outputs are added, then through
// ALLPASS_COUNT allpass sections in series, and the result is divided by
// (COMB_COUNT + ALLPASS_COUNT) and saturated to one 16-bit wet sample. Stored
// values saturate to 24 bits, delays are in samples (0 acts as 1, anything
// above DELAY_DEPTH clamps to it) and gains are unsigned Q1.15. One item is
// in flight at a time: the schedule from acceptance to the next accept is
// set by the single shared gain multiplier and the one read and one write
// port of each delay memory; a filter whose head sits past a delay that was
// shortened runs the iterative remainder once to wrap it. The result sits
// in an output register, so the next beat is taken while it waits. After
// reset the delay memories are swept to zero with in_ready low; settings
// writes are taken throughout.
// Write settings only while the block is idle.
// ----------------------------------------------------------------------------
module schroeder_reverb_core import srvb_pkg::*; #(
  parameter int COMB_COUNT    = COMB_COUNT_DEF,
  parameter int ALLPASS_COUNT = ALLPASS_COUNT_DEF,
  parameter int DELAY_DEPTH   = DELAY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input samples
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  // wet result
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_wet_sample,
  // settings: 0 comb delays, 1 comb gains, 2 allpass delays and gains
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int IW = idx_w(COMB_COUNT, ALLPASS_COUNT);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [IW-1:0] idx;

  // Settings registers never stall
  assign cfg_ready = 1'b1;

  // Sequencer: owns the filter index and issues one datapath op per cycle
  srvb_ctrl #(
    .COMB_COUNT    (COMB_COUNT),
    .ALLPASS_COUNT (ALLPASS_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  // Datapath: memories, heads, multiplier, remainder and output register
  srvb_dp #(
    .COMB_COUNT    (COMB_COUNT),
    .ALLPASS_COUNT (ALLPASS_COUNT),
    .DELAY_DEPTH   (DELAY_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .idx             (idx),
    .sts             (sts),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_wet_sample  (out_wet_sample),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

endmodule

>>> bench/schroeder_reverb_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schroeder_reverb_core_tb
// Self-checking bench for the mono Schroeder reverberator core.
// ----------------------------------------------------------------------------
// Drives stereo sample beats through the block under several delay and gain
// settings, keeps a bit-true copy of the comb and allpass delay lines, and
// compares every wet sample with the predicted one. Both sides stall at
// random; one phase runs with no stalls, one phase holds the output off long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
module schroeder_reverb_core_tb;
  import srvb_pkg::*;

  localparam int COMB_N  = COMB_COUNT_DEF;
  localparam int AP_N    = ALLPASS_COUNT_DEF;
  localparam int DEPTH   = DELAY_DEPTH_DEF;
  localparam int SETTLE  = 60;    // one beat plus the one-off head wrap
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int QUIET_PHASE = 4;
  localparam int HOLD_PHASE  = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint S24_HI = 64'sd8388607;
  localparam longint S24_LO = -64'sd8388608;

  // Bit-true copy of the reverb state plus the expected wet samples.
  class reverb_scoreboard;
    logic [COMB_DLY_REG_W-1:0]  comb_delays;
    logic [COMB_GAIN_REG_W-1:0] comb_gains;
    logic [AP_REG_W-1:0]        ap_settings;
    bit signed [STORE_W-1:0] comb_line [COMB_N*DEPTH];
    bit signed [STORE_W-1:0] ap_in_line [AP_N*DEPTH];
    bit signed [STORE_W-1:0] ap_out_line [AP_N*DEPTH];
    int comb_head [COMB_N];
    int ap_head [AP_N];
    logic signed [SAMPLE_W-1:0] wet_due [$];
    int samples;
    int checked;
    int clipped;
    int errors;

    function new();
      comb_delays = COMB_DELAYS_RST;
      comb_gains  = COMB_GAINS_RST;
      ap_settings = AP_SETTINGS_RST;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_COMB_DELAYS: comb_delays = val[COMB_DLY_REG_W-1:0];
        CFG_COMB_GAINS:  comb_gains  = val[COMB_GAIN_REG_W-1:0];
        CFG_AP_SETTINGS: ap_settings = val[AP_REG_W-1:0];
        default: ;
      endcase
    endfunction

    // g*v in Q1.15, rounded half up
    function longint round_gain(bit [GAIN_W-1:0] g, longint v);
      longint p;
      p = longint'(g) * v + 16384;
      return p >>> 15;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // zero acts as one, anything past the line depth clamps to it
    function int span(bit [DLY_W-1:0] f);
      if (f == 0) return 1;
      if (f > DEPTH) return DEPTH;
      return int'(f);
    endfunction

    // Run one dry beat through the combs and allpasses; queue the wet sample.
    function void take_sample(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      longint dry, acc, x, y, q;
      int k, d, h, idx;
      bit [GAIN_W-1:0] g;
      dry = longint'(l) + longint'(r);
      acc = 0;
      for (k = 0; k < COMB_N; k++) begin
        d = span(comb_delays[DLY_W*(k%4) +: DLY_W]);
        g = comb_gains[GAIN_W*(k%4) +: GAIN_W];
        h = comb_head[k] % DEPTH;
        idx = k*DEPTH + h;
        y = clip(dry + round_gain(g, comb_line[idx]), S24_LO, S24_HI);
        comb_line[idx] = y[STORE_W-1:0];
        comb_head[k] = (h + 1) % d;
        acc += y;
      end
      x = clip(acc, S24_LO, S24_HI);
      for (k = 0; k < AP_N; k++) begin
        d = span(ap_settings[DLY_W*(k%2) +: DLY_W]);
        g = ap_settings[AP_GAIN_LSB + GAIN_W*(k%2) +: GAIN_W];
        h = ap_head[k] % DEPTH;
        idx = k*DEPTH + h;
        y = -round_gain(g, x) + ap_in_line[idx] + round_gain(g, ap_out_line[idx]);
        y = clip(y, S24_LO, S24_HI);
        ap_in_line[idx] = x[STORE_W-1:0];
        ap_out_line[idx] = y[STORE_W-1:0];
        ap_head[k] = (h + 1) % d;
        x = y;
      end
      q = x / (COMB_N + AP_N);
      if (q > 32767 || q < -32768) clipped++;
      q = clip(q, -32768, 32767);
      wet_due.push_back(q[SAMPLE_W-1:0]);
      samples++;
    endfunction

    function void check_wet(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (wet_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("wet sample %0d arrived with none expected", got);
        return;
      end
      want = wet_due.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("wet sample #%0d: expected %0d, got %0d", checked, want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_left_sample;
  logic signed [SAMPLE_W-1:0] in_right_sample;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_W-1:0] out_wet_sample;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  reverb_scoreboard sb;
  bit quiet;      // no stalls on either side while set
  bit hold_req;   // ask the receiver for one long hold-off
  int holds_done;
  int settings_used;

  always #6 clk = ~clk;

  schroeder_reverb_core #(
    .COMB_COUNT(COMB_N),
    .ALLPASS_COUNT(AP_N),
    .DELAY_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_left_sample(in_left_sample),
    .in_right_sample(in_right_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_wet_sample(out_wet_sample),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Offer one beat and hold it until the block takes it. Valid stays high on
  // return so a following beat goes out back to back.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r);
    in_valid <= 1'b1;
    in_left_sample <= l;
    in_right_sample <= r;
    do @(posedge clk); while (!in_ready);
    sb.take_sample(l, r);
  endtask

  // Drop valid and idle; n sets the gap (n >= 1).
  task automatic idle_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Write one register; valid is left high for back-to-back writes, the
  // caller drops it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // Wait until every wet sample is back, then let the block settle.
  task automatic wait_drained();
    do @(posedge clk); while (sb.wet_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly short delays so the feedback shows within a phase; the extremes
  // (zero and the longest field value) turn up now and then.
  function automatic logic [DLY_W-1:0] pick_delay();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 65) return DLY_W'($urandom_range(1, 40));
    if (roll < 85) return DLY_W'($urandom_range(41, 600));
    if (roll < 95) return DLY_W'($urandom_range(601, 8190));
    return '1;
  endfunction

  // Zero, full scale (about 2.0), a decaying gain, or anything.
  function automatic logic [GAIN_W-1:0] pick_gain();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 60) return GAIN_W'($urandom_range(16384, 32000));
    return GAIN_W'($urandom);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return SAMPLE_W'($urandom);
    if (roll < 80) return SAMPLE_W'($urandom_range(0, 511) - 256);
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Program all three registers with fresh random settings. Unused upper
  // bits of the write data are random too, so masking gets exercised.
  task automatic program_random_settings(input bit tight);
    logic [CFG_DATA_W-1:0] w;
    int k;
    w = {$urandom, $urandom};
    for (k = 0; k < 4; k++) begin
      w[DLY_W*k +: DLY_W] = tight ? DLY_W'($urandom_range(1, 3)) : pick_delay();
    end
    write_reg(CFG_COMB_DELAYS, w);
    for (k = 0; k < 4; k++) w[GAIN_W*k +: GAIN_W] = pick_gain();
    write_reg(CFG_COMB_GAINS, w);
    w = {$urandom, $urandom};
    for (k = 0; k < 2; k++) begin
      w[DLY_W*k +: DLY_W] = tight ? DLY_W'($urandom_range(1, 3)) : pick_delay();
      w[AP_GAIN_LSB + GAIN_W*k +: GAIN_W] = pick_gain();
    end
    write_reg(CFG_AP_SETTINGS, w);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Feed n random beats; random gaps after about a quarter of the beats shift
  // the next offer within the block's schedule unless the quiet flag is set.
  task automatic feed_samples(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_sample(pick_sample(), pick_sample());
      if (!quiet && $urandom_range(0, 99) < 25) idle_input($urandom_range(1, 20));
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: check every accepted wet beat, stall about one cycle in ten,
  // and on request hold off for a long stretch so the block backs up.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_wet(out_wet_sample);
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // Main stimulus.
  initial begin
    int p;
    sb = new();
    in_valid <= 1'b0;
    in_left_sample <= '0;
    in_right_sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_COMB_DELAYS;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: silence, full-scale sums of both signs, and the
    // smallest nonzero inputs. The first beat waits out the clearing sweep.
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'shFFFF, 16'shFFFF);
    send_sample(16'sh0001, 16'sh0000);
    send_sample(16'sh0000, 16'sh8000);
    send_sample(16'sh4000, 16'sh4000);
    in_valid <= 1'b0;
    wait_drained();

    // Zero delays (act as one) with full-scale gains: the lines double every
    // beat, so comb, comb sum, allpass and output all hit saturation.
    write_reg(CFG_COMB_DELAYS, '0);
    write_reg(CFG_COMB_GAINS, '1);
    write_reg(CFG_AP_SETTINGS, {6'h3F, 32'hFFFF_FFFF, 26'h0});
    cfg_valid <= 1'b0;
    settings_used++;
    repeat (6) send_sample(16'sh7FFF, 16'sh7FFF);
    repeat (2) send_sample(16'sh8000, 16'sh8000);
    in_valid <= 1'b0;
    wait_drained();

    // A write to the unused index must change nothing; then the longest
    // delays with zero gains, stray upper data bits set.
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_COMB_DELAYS, '1);
    write_reg(CFG_COMB_GAINS, '0);
    write_reg(CFG_AP_SETTINGS, {6'h3F, 32'h0, 26'h3FF_FFFF});
    cfg_valid <= 1'b0;
    settings_used++;
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh3039, 16'shEF1F);
    send_sample(16'shAAAA, 16'sh5555);
    send_sample(16'sh5555, 16'shAAAA);
    in_valid <= 1'b0;
    wait_drained();

    // Random phases. The first one shortens every delay below the current
    // heads so the one-off wrap from a stale head gets hit.
    for (p = 0; p < RAND_PHASES; p++) begin
      program_random_settings(p == 0);
      quiet = (p == QUIET_PHASE);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      feed_samples(PHASE_ITEMS);
      wait_drained();
    end
    quiet = 1'b0;

    $display("covered %0d samples under %0d settings, %0d wet outputs clipped,",
             sb.samples, settings_used, sb.clipped);
    $display("%0d long output hold-offs, %0d wet samples checked, %0d mismatches",
             holds_done, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.wet_due.size() == 0) begin
      $display("schroeder_reverb_core_tb passed");
    end else begin
      $display("schroeder_reverb_core_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, clearing sweep included.
  initial begin
    #12ms;
    $display("schroeder_reverb_core_tb failed");
    $finish;
  end

endmodule
